### design/assert_macros.svh
// Assertion macros shared by the presence trigger interference filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define PTIF_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ptif assertion failed");
// Clocked check that also holds during reset.
`define PTIF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ptif assertion failed");
`else
`define PTIF_ASSERT_CLK(label, clk, rst_n, prop)
`define PTIF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### design/ptif_pkg.sv
// Shared types and constants for the presence trigger interference filter.
`default_nettype none

package ptif_pkg;

  // default datapath widths
  localparam int TIME_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 16;

  // configuration register widths
  localparam int EN_W       = 1;
  localparam int MS_W       = 24;
  localparam int EDGE_LIM_W = 16;
  localparam int STREAK_W   = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE        = 3'd0,
    REG_CONFIRM_DELAY = 3'd1,
    REG_WINDOW        = 3'd2,
    REG_HIGH_LIMIT    = 3'd3,
    REG_EDGE_LIMIT    = 3'd4,
    REG_CYCLES_LOCK   = 3'd5,
    REG_LOCKOUT_LEN   = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic [EN_W-1:0]       ENABLE_RST        = 1'b1;
  localparam logic [MS_W-1:0]       CONFIRM_DELAY_RST = 24'd5000;
  localparam logic [MS_W-1:0]       WINDOW_RST        = 24'd20000;
  localparam logic [MS_W-1:0]       HIGH_LIMIT_RST    = 24'd10000;
  localparam logic [EDGE_LIM_W-1:0] EDGE_LIMIT_RST    = 16'd10;
  localparam logic [STREAK_W-1:0]   CYCLES_LOCK_RST   = 8'd3;
  localparam logic [MS_W-1:0]       LOCKOUT_LEN_RST   = 24'd600000;

  // input kind (tuser)
  localparam logic KIND_LEVEL  = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;

  // phase state, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_CONFIRM = 4'b0010,
    PH_WINDOW  = 4'b0100,
    PH_LOCK    = 4'b1000
  } phase_t;

  // phase codes as seen on the result word
  localparam int PHASE_CODE_W = 2;
  localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_IDLE    = 2'd0;
  localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_CONFIRM = 2'd1;
  localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_WINDOW  = 2'd2;
  localparam logic [PHASE_CODE_W-1:0] PHASE_CODE_LOCK    = 2'd3;

  localparam int OUT_DATA_W = 8;

  // result word fields
  typedef struct packed {
    logic                    pad;
    logic [PHASE_CODE_W-1:0] phase_out;
    logic                    canceled;
    logic                    lock_started;
    logic                    noisy;
    logic                    window_done;
    logic                    ready_res;
  } result_t;

endpackage

`default_nettype wire

### design/presence_trigger_interference_filter_unit.sv
// Top level of the presence trigger interference filter.
`default_nettype none
`include "assert_macros.svh"

// Presence trigger interference filter. Each input word is a presence-sensor
// level sample with a millisecond timestamp, or a cancel (in_tuser = 1). An
// active sample in idle opens a cycle; once the confirm delay has passed the
// result word carries ready_res, and once the window has passed since cycle
// start the cycle is judged noisy on high time or rising-edge count. A run of
// noisy cycles starts a lockout during which no cycle opens. Every input word
// yields exactly one result word. Throughput is one word per clock unless the
// result side stalls; a word passes the input register, then the state update
// (which sets the rate) and result register. All phase, counter and timer logic
// for one word is one pass of compares and saturating adds on TIME_BITS-wide
// values. Configuration must be written through cfg_wen/cfg_addr/cfg_wdata only
// while no word is in flight (not enforced); out-of-range indexes are ignored.
module presence_trigger_interference_filter_unit #(
  parameter int TIME_BITS  = ptif_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = ptif_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input words
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [0] level_active, [TIME_BITS:1] now_ms, rest zero
  input  logic [((TIME_BITS+8)/8)*8-1:0]         in_tdata,
  // [0] kind (0 level sample, 1 cancel)
  input  logic                                   in_tuser,
  // result words
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [0] ready_res, [1] window_done, [2] noisy, [3] lock_started,
  // [4] canceled, [6:5] phase_out, [7] zero
  output logic [ptif_pkg::OUT_DATA_W-1:0]        out_tdata,
  // configuration write port
  input  logic                                   cfg_wen,
  input  logic [ptif_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [ptif_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CMP_W = (COUNT_BITS > ptif_pkg::EDGE_LIM_W) ? COUNT_BITS
                                                             : ptif_pkg::EDGE_LIM_W;

  // ---------------- configuration registers ----------------
  logic [ptif_pkg::EN_W-1:0]       cfg_enable_r;
  logic [ptif_pkg::MS_W-1:0]       cfg_confirm_r;
  logic [ptif_pkg::MS_W-1:0]       cfg_window_r;
  logic [ptif_pkg::MS_W-1:0]       cfg_high_lim_r;
  logic [ptif_pkg::EDGE_LIM_W-1:0] cfg_edge_lim_r;
  logic [ptif_pkg::STREAK_W-1:0]   cfg_cyc_lock_r;
  logic [ptif_pkg::MS_W-1:0]       cfg_lock_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_enable_r   <= ptif_pkg::ENABLE_RST;
      cfg_confirm_r  <= ptif_pkg::CONFIRM_DELAY_RST;
      cfg_window_r   <= ptif_pkg::WINDOW_RST;
      cfg_high_lim_r <= ptif_pkg::HIGH_LIMIT_RST;
      cfg_edge_lim_r <= ptif_pkg::EDGE_LIMIT_RST;
      cfg_cyc_lock_r <= ptif_pkg::CYCLES_LOCK_RST;
      cfg_lock_len_r <= ptif_pkg::LOCKOUT_LEN_RST;
    end else if (cfg_wen) begin
      unique case (ptif_pkg::cfg_reg_t'(cfg_addr))
        ptif_pkg::REG_ENABLE:        cfg_enable_r   <= cfg_wdata[ptif_pkg::EN_W-1:0];
        ptif_pkg::REG_CONFIRM_DELAY: cfg_confirm_r  <= cfg_wdata[ptif_pkg::MS_W-1:0];
        ptif_pkg::REG_WINDOW:        cfg_window_r   <= cfg_wdata[ptif_pkg::MS_W-1:0];
        ptif_pkg::REG_HIGH_LIMIT:    cfg_high_lim_r <= cfg_wdata[ptif_pkg::MS_W-1:0];
        ptif_pkg::REG_EDGE_LIMIT:    cfg_edge_lim_r <= cfg_wdata[ptif_pkg::EDGE_LIM_W-1:0];
        ptif_pkg::REG_CYCLES_LOCK:   cfg_cyc_lock_r <= cfg_wdata[ptif_pkg::STREAK_W-1:0];
        ptif_pkg::REG_LOCKOUT_LEN:   cfg_lock_len_r <= cfg_wdata[ptif_pkg::MS_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                 in_valid_r;
  logic                 in_kind_r;
  logic                 in_lvl_r;
  logic [TIME_BITS-1:0] in_now_r;
  logic                 out_valid_r;
  ptif_pkg::result_t    out_data_r;
  logic                 advance;

  // the state update fires whenever the result register can take a word
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= in_tuser;
      in_lvl_r  <= in_tdata[0];
      in_now_r  <= in_tdata[TIME_BITS:1];
    end
  end

  // ---------------- filter state ----------------
  ptif_pkg::phase_t               phase_r,        phase_nxt;
  logic [TIME_BITS-1:0]           phase_start_r,  phase_start_nxt;
  logic [TIME_BITS-1:0]           cycle_start_r,  cycle_start_nxt;
  logic [COUNT_BITS-1:0]          edge_count_r,   edge_count_nxt;
  logic                           prev_level_r,   prev_level_nxt;
  logic                           high_run_r,     high_run_nxt;
  logic [TIME_BITS-1:0]           high_start_r,   high_start_nxt;
  logic [TIME_BITS-1:0]           high_total_r,   high_total_nxt;
  logic [ptif_pkg::STREAK_W-1:0]  streak_r,       streak_nxt;
  logic [TIME_BITS-1:0]           lock_until_r,   lock_until_nxt;

  // ---------------- shared datapath ----------------
  logic                           lvl;
  logic [TIME_BITS-1:0]           now;
  logic                           rise;
  logic [TIME_BITS-1:0]           hs_eff;     // interval start after this sample
  logic [TIME_BITS-1:0]           delta;      // now - hs_eff, floored at 0
  logic [TIME_BITS:0]             sum_w;
  logic [TIME_BITS-1:0]           sum_sat;    // high_total + delta, saturated
  logic [TIME_BITS-1:0]           el_phase;
  logic [TIME_BITS-1:0]           el_cycle;
  logic [TIME_BITS:0]             lock_w;
  logic [TIME_BITS-1:0]           lock_sat;
  logic [COUNT_BITS-1:0]          edge_new;
  logic [ptif_pkg::STREAK_W-1:0]  streak_inc;
  logic [TIME_BITS-1:0]           fin;
  logic                           past_lock;

  assign lvl  = in_lvl_r;
  assign now  = in_now_r;
  assign rise = lvl && !prev_level_r;

  // window phase restarts interval timing on any active sample with no
  // interval running; confirm phase only on a rising edge
  always_comb begin
    if (phase_r == ptif_pkg::PH_WINDOW) begin
      hs_eff = (lvl && (!high_run_r || !prev_level_r)) ? now : high_start_r;
    end else begin
      hs_eff = rise ? now : high_start_r;
    end
  end

  assign delta    = (now > hs_eff) ? (now - hs_eff) : '0;
  assign sum_w    = {1'b0, high_total_r} + {1'b0, delta};
  assign sum_sat  = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
  assign el_phase = (now > phase_start_r) ? (now - phase_start_r) : '0;
  assign el_cycle = (now > cycle_start_r) ? (now - cycle_start_r) : '0;
  assign lock_w   = {1'b0, now} + (TIME_BITS+1)'(cfg_lock_len_r);
  assign lock_sat = lock_w[TIME_BITS] ? '1 : lock_w[TIME_BITS-1:0];
  assign past_lock = (now >= lock_until_r);

  assign edge_new   = (rise && (edge_count_r != '1)) ? (edge_count_r + COUNT_BITS'(1))
                                                     : edge_count_r;
  assign streak_inc = (streak_r != '1) ? (streak_r + ptif_pkg::STREAK_W'(1)) : streak_r;
  assign fin        = (lvl || high_run_r) ? sum_sat : high_total_r;

  logic f_ready, f_done, f_noisy, f_locked, f_canceled;
  logic run_after;
  logic is_noisy;

  assign is_noisy = (fin >= TIME_BITS'(cfg_high_lim_r)) ||
                    (CMP_W'(edge_new) >= CMP_W'(cfg_edge_lim_r));

  always_comb begin
    phase_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    cycle_start_nxt = cycle_start_r;
    edge_count_nxt  = edge_count_r;
    prev_level_nxt  = prev_level_r;
    high_run_nxt    = high_run_r;
    high_start_nxt  = high_start_r;
    high_total_nxt  = high_total_r;
    streak_nxt      = streak_r;
    lock_until_nxt  = lock_until_r;
    f_ready         = 1'b0;
    f_done          = 1'b0;
    f_noisy         = 1'b0;
    f_locked        = 1'b0;
    f_canceled      = 1'b0;
    run_after       = lvl && (high_run_r || rise);

    // clearing a cycle only needs the phase: the cycle fields are all
    // reloaded when the next cycle opens
    if (in_kind_r == ptif_pkg::KIND_CANCEL) begin
      if (phase_r == ptif_pkg::PH_CONFIRM || phase_r == ptif_pkg::PH_WINDOW) begin
        phase_nxt  = ptif_pkg::PH_IDLE;
        f_canceled = 1'b1;
      end
    end else if (!cfg_enable_r[0]) begin
      phase_nxt = ptif_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        ptif_pkg::PH_IDLE: begin
          if (past_lock && lvl) begin
            phase_nxt       = ptif_pkg::PH_CONFIRM;
            phase_start_nxt = now;
            cycle_start_nxt = now;
            edge_count_nxt  = COUNT_BITS'(1);
            prev_level_nxt  = 1'b1;
            high_start_nxt  = now;
            high_run_nxt    = 1'b1;
            high_total_nxt  = '0;
          end
        end
        ptif_pkg::PH_CONFIRM: begin
          if (!lvl && high_run_r) begin
            high_total_nxt = sum_sat;
          end
          high_run_nxt   = run_after;
          high_start_nxt = hs_eff;
          edge_count_nxt = edge_new;
          prev_level_nxt = lvl;
          if (el_phase >= TIME_BITS'(cfg_confirm_r)) begin
            if (run_after) begin
              high_total_nxt = sum_sat;
              high_start_nxt = now;
            end
            f_ready         = 1'b1;
            phase_nxt       = ptif_pkg::PH_WINDOW;
            phase_start_nxt = now;
          end
        end
        ptif_pkg::PH_WINDOW: begin
          if (!lvl && high_run_r) begin
            high_total_nxt = sum_sat;
          end
          high_run_nxt   = lvl;
          high_start_nxt = hs_eff;
          edge_count_nxt = edge_new;
          prev_level_nxt = lvl;
          if (el_cycle >= TIME_BITS'(cfg_window_r)) begin
            f_done  = 1'b1;
            f_noisy = is_noisy;
            if (is_noisy) begin
              if (streak_inc >= cfg_cyc_lock_r) begin
                // lockout keeps the cycle counters as they stand
                phase_nxt      = ptif_pkg::PH_LOCK;
                lock_until_nxt = lock_sat;
                streak_nxt     = '0;
                f_locked       = 1'b1;
              end else begin
                streak_nxt = streak_inc;
                phase_nxt  = ptif_pkg::PH_IDLE;
              end
            end else begin
              streak_nxt = '0;
              phase_nxt  = ptif_pkg::PH_IDLE;
            end
          end
        end
        ptif_pkg::PH_LOCK: begin
          if (past_lock) begin
            phase_nxt = ptif_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = ptif_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ptif_pkg::PH_IDLE;
      streak_r     <= '0;
      lock_until_r <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      streak_r     <= streak_nxt;
      lock_until_r <= lock_until_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      phase_start_r <= phase_start_nxt;
      cycle_start_r <= cycle_start_nxt;
      edge_count_r  <= edge_count_nxt;
      prev_level_r  <= prev_level_nxt;
      high_run_r    <= high_run_nxt;
      high_start_r  <= high_start_nxt;
      high_total_r  <= high_total_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [ptif_pkg::PHASE_CODE_W-1:0] phase_code;

  always_comb begin
    unique case (phase_nxt)
      ptif_pkg::PH_IDLE:    phase_code = ptif_pkg::PHASE_CODE_IDLE;
      ptif_pkg::PH_CONFIRM: phase_code = ptif_pkg::PHASE_CODE_CONFIRM;
      ptif_pkg::PH_WINDOW:  phase_code = ptif_pkg::PHASE_CODE_WINDOW;
      ptif_pkg::PH_LOCK:    phase_code = ptif_pkg::PHASE_CODE_LOCK;
      default:              phase_code = ptif_pkg::PHASE_CODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.pad          <= 1'b0;
      out_data_r.phase_out    <= phase_code;
      out_data_r.canceled     <= f_canceled;
      out_data_r.lock_started <= f_locked;
      out_data_r.noisy        <= f_noisy;
      out_data_r.window_done  <= f_done;
      out_data_r.ready_res    <= f_ready;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  // a lockout flagged on a word leaves the phase locked
  `PTIF_ASSERT_CLK(a_lock_enters_lock, clk, rst_n, (advance && f_locked) |=> (phase_r == ptif_pkg::PH_LOCK))
  // a noisy verdict only comes with the end of a window
  `PTIF_ASSERT_CLK(a_noisy_needs_done, clk, rst_n, out_valid_r |-> (!out_data_r.noisy || out_data_r.window_done))
  // a held input word is not dropped while the result side stalls
  `PTIF_ASSERT_CLK(a_in_held, clk, rst_n, (in_valid_r && !advance) |=> in_valid_r)
  // the filter state moves only when a word is processed
  `PTIF_ASSERT_CLK(a_state_on_advance, clk, rst_n, !advance |=> ($stable(phase_r) && $stable(streak_r)))
  // ready and window end never land on the same word
  `PTIF_ASSERT_CLK(a_ready_done_excl, clk, rst_n, advance |-> !(f_ready && f_done))

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking bench for the presence trigger interference filter unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptif_pkg::*;

  localparam int TW       = TIME_BITS_DEF;
  localparam int CW       = COUNT_BITS_DEF;
  localparam int DATA_W   = ((TW + 8) / 8) * 8;
  localparam int SETTLE   = 4;     // idle cycles before a register write
  localparam int TAIL     = 8;     // cycles watched after the last result
  localparam int HOLD_LEN = 400;   // long receiver back-pressure stretch
  localparam int WD_LIMIT = 4000;  // cycles with no traffic before giving up
  localparam int MAX_ERR_SHOWN = 10;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;  // no register behind it
  localparam logic [MS_W-1:0]       MS_MAX     = '1;
  localparam logic [TW-1:0]         STAMP_MAX  = '1;

  // what the sender does next
  typedef enum logic [1:0] {
    OP_WORD,   // offer one input word
    OP_CFG,    // register write once the block is quiet
    OP_DRAIN   // pause until every result is back
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  kind;
    logic                  lvl;
    logic [TW-1:0]         stamp;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    logic [2:0]            gap;
  } entry_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata   = '0;   // [0] level_active, [TW:1] now_ms
  logic                  in_tuser   = 1'b0; // [0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [0] ready .. [4] canceled, [6:5] phase
  logic                  cfg_wen    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  presence_trigger_interference_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter state mirror (register copies plus cycle state)
  // ---------------------------------------------------------------------------
  logic                  cf_en          = ENABLE_RST;
  logic [MS_W-1:0]       cf_confirm     = CONFIRM_DELAY_RST;
  logic [MS_W-1:0]       cf_window      = WINDOW_RST;
  logic [MS_W-1:0]       cf_hi_limit    = HIGH_LIMIT_RST;
  logic [EDGE_LIM_W-1:0] cf_rise_limit  = EDGE_LIMIT_RST;
  logic [STREAK_W-1:0]   cf_lock_streak = CYCLES_LOCK_RST;
  logic [MS_W-1:0]       cf_lock_len    = LOCKOUT_LEN_RST;

  logic [PHASE_CODE_W-1:0] ph        = PHASE_CODE_IDLE;
  logic [TW-1:0]           seg_start = '0;  // start of current phase
  logic [TW-1:0]           cyc_start = '0;  // start of the cycle
  logic [CW-1:0]           rise_cnt  = '0;
  logic                    last_lvl  = 1'b0;
  logic                    hi_on     = 1'b0; // a high interval is open
  logic [TW-1:0]           hi_start  = '0;
  logic [TW-1:0]           hi_sum    = '0;
  logic [7:0]              noisy_run = '0;
  logic [TW-1:0]           lock_end  = '0;

  function automatic logic [TW-1:0] sat_add(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? STAMP_MAX : s[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] sat_sub(logic [TW-1:0] a, logic [TW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // streak and lockout end survive a cleared cycle
  function automatic void clear_cycle();
    ph        = PHASE_CODE_IDLE;
    seg_start = '0;
    cyc_start = '0;
    rise_cnt  = '0;
    last_lvl  = 1'b0;
    hi_on     = 1'b0;
    hi_start  = '0;
    hi_sum    = '0;
  endfunction

  function automatic void track_edge(logic lvl, logic [TW-1:0] stamp);
    if (lvl && !last_lvl) begin
      if (rise_cnt != '1) rise_cnt++;
      hi_start = stamp;
      hi_on    = 1'b1;
    end
    last_lvl = lvl;
  endfunction

  // one accepted input word -> the result word it must produce
  function automatic result_t filter_update(logic cancel, logic lvl, logic [TW-1:0] stamp);
    result_t       r;
    logic [TW-1:0] fin;
    r = '0;
    if (cancel) begin
      // no effect in idle or lockout
      if (ph == PHASE_CODE_CONFIRM || ph == PHASE_CODE_WINDOW) begin
        clear_cycle();
        r.canceled = 1'b1;
      end
    end else if (!cf_en) begin
      clear_cycle();
    end else begin
      case (ph)
        PHASE_CODE_IDLE: begin
          if (stamp >= lock_end && lvl) begin
            ph        = PHASE_CODE_CONFIRM;
            seg_start = stamp;
            cyc_start = stamp;
            rise_cnt  = 1;
            last_lvl  = 1'b1;
            hi_start  = stamp;
            hi_on     = 1'b1;
            hi_sum    = '0;
          end
        end
        PHASE_CODE_CONFIRM: begin
          if (!lvl && hi_on) begin
            hi_sum = sat_add(hi_sum, sat_sub(stamp, hi_start));
            hi_on  = 1'b0;
          end
          track_edge(lvl, stamp);
          if (sat_sub(stamp, seg_start) >= cf_confirm) begin
            // bank the open high interval at the phase boundary
            if (hi_on) begin
              hi_sum   = sat_add(hi_sum, sat_sub(stamp, hi_start));
              hi_start = stamp;
            end
            r.ready_res = 1'b1;
            ph          = PHASE_CODE_WINDOW;
            seg_start   = stamp;
          end
        end
        PHASE_CODE_WINDOW: begin
          if (lvl) begin
            if (!hi_on) begin
              hi_on    = 1'b1;
              hi_start = stamp;
            end
          end else if (hi_on) begin
            hi_sum = sat_add(hi_sum, sat_sub(stamp, hi_start));
            hi_on  = 1'b0;
          end
          track_edge(lvl, stamp);
          if (sat_sub(stamp, cyc_start) >= cf_window) begin
            fin = hi_on ? sat_add(hi_sum, sat_sub(stamp, hi_start)) : hi_sum;
            r.window_done = 1'b1;
            r.noisy       = (fin >= cf_hi_limit) || (rise_cnt >= cf_rise_limit);
            if (r.noisy) begin
              if (noisy_run != 8'hFF) noisy_run++;
              if (noisy_run >= cf_lock_streak) begin
                // lockout keeps the cycle counters as they are
                ph             = PHASE_CODE_LOCK;
                lock_end       = sat_add(stamp, cf_lock_len);
                noisy_run      = '0;
                r.lock_started = 1'b1;
              end else begin
                clear_cycle();
              end
            end else begin
              noisy_run = '0;
              clear_cycle();
            end
          end
        end
        default: begin
          // leaving lockout never opens a cycle on the same word
          if (stamp >= lock_end) clear_cycle();
        end
      endcase
    end
    r.phase_out = ph;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store and bookkeeping
  // ---------------------------------------------------------------------------
  entry_t      sample_q[$];
  result_t     due_results[$];

  logic        in_fire     = 1'b0;  // handshakes seen at the last rising edge
  logic        out_fire    = 1'b0;
  logic        stim_done   = 1'b0;
  logic        timed_out   = 1'b0;
  int          quiet       = 0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  int          hold_left   = 0;
  logic        hold_done   = 1'b0;
  int unsigned hold_after  = 32'hFFFF_FFFF;  // result count that starts the long hold
  logic        rx_calm     = 1'b0;
  int          idle_cycles = 0;
  int          errors      = 0;

  int unsigned words_queued = 0;
  int unsigned words_in     = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned readies      = 0;
  int unsigned windows      = 0;
  int unsigned lockouts     = 0;
  int unsigned cancels      = 0;

  // generator state
  logic [TW-1:0] t_now   = '0;
  logic          lvl_now = 1'b0;
  logic          tx_calm = 1'b0;

  function automatic void push_word(logic kind, logic lvl, logic [TW-1:0] stamp);
    entry_t e;
    e       = '0;
    e.op    = OP_WORD;
    e.kind  = kind;
    e.lvl   = lvl;
    e.stamp = stamp;
    e.gap   = tx_calm ? 3'd0 : 3'($urandom_range(0, 5));
    sample_q.push_back(e);
    words_queued++;
  endfunction

  function automatic void push_op(op_t op, logic [CFG_ADDR_W-1:0] addr,
                                  logic [CFG_DATA_W-1:0] data);
    entry_t e;
    e      = '0;
    e.op   = op;
    e.addr = addr;
    e.data = data;
    sample_q.push_back(e);
  endfunction

  // all registers plus the unused index; junk in the bits above each narrower register
  function automatic void load_settings(logic en, logic [MS_W-1:0] confirm,
      logic [MS_W-1:0] window, logic [MS_W-1:0] hi_lim, logic [EDGE_LIM_W-1:0] rise_lim,
      logic [STREAK_W-1:0] streak, logic [MS_W-1:0] lock_len);
    logic [31:0] junk;
    junk = $urandom();
    push_op(OP_CFG, REG_ENABLE, {junk[22:0], en});
    push_op(OP_CFG, REG_CONFIRM_DELAY, confirm);
    push_op(OP_CFG, REG_WINDOW, window);
    push_op(OP_CFG, REG_HIGH_LIMIT, hi_lim);
    push_op(OP_CFG, REG_EDGE_LIMIT, {junk[30:23], rise_lim});
    push_op(OP_CFG, REG_CYCLES_LOCK, {junk[15:0], streak});
    push_op(OP_CFG, REG_LOCKOUT_LEN, lock_len);
    push_op(OP_CFG, REG_UNUSED, CFG_DATA_W'($urandom()));
  endfunction

  // mostly well-formed level traffic; some cancels and stamps that step back
  function automatic void gen_phase(int n, int unsigned window, logic keep_calm);
    int unsigned   dscale;
    int unsigned   roll;
    int unsigned   back;
    logic [TW-1:0] stamp;
    logic [63:0]   noise;
    dscale = window / 6 + 2;
    for (int i = 0; i < n; i++) begin
      if (!keep_calm && (i % 30) == 0) tx_calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        noise = {$urandom(), $urandom()};
        push_word(KIND_CANCEL, noise[0], noise[TW:1]);
      end else begin
        if (roll < 6) begin
          back  = $urandom_range(0, dscale);
          stamp = (t_now > back) ? t_now - back : '0;
        end else begin
          t_now = t_now + $urandom_range(0, dscale);
          stamp = t_now;
        end
        if ($urandom_range(0, 99) < 35) lvl_now = ~lvl_now;
        push_word(KIND_LEVEL, lvl_now, stamp);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: handshakes, prediction at acceptance, result check, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      want = filter_update(in_tuser == KIND_CANCEL, in_tdata[0], in_tdata[TW:1]);
      due_results.push_back(want);
      words_in++;
      readies  += want.ready_res;
      windows  += want.window_done;
      lockouts += want.lock_started;
      cancels  += want.canceled;
    end
    if (out_fire) begin
      got = result_t'(out_tdata);
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_ERR_SHOWN)
          $display("result word %h arrived with nothing outstanding", out_tdata);
      end else begin
        want = due_results.pop_front();
        if (got.ready_res    !== want.ready_res    || got.window_done !== want.window_done ||
            got.noisy        !== want.noisy        || got.canceled    !== want.canceled    ||
            got.lock_started !== want.lock_started || got.phase_out   !== want.phase_out) begin
          errors++;
          if (errors <= MAX_ERR_SHOWN)
            $display({"result %0d: expected rdy %b done %b noisy %b lock %b cancel %b ph %0d,",
                      " got rdy %b done %b noisy %b lock %b cancel %b ph %0d"},
                     results_seen, want.ready_res, want.window_done, want.noisy,
                     want.lock_started, want.canceled, want.phase_out, got.ready_res,
                     got.window_done, got.noisy, got.lock_started, got.canceled,
                     got.phase_out);
        end
      end
      results_seen++;
    end
    if (in_fire || out_fire || cfg_wen || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) timed_out = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: walks the stimulus queue, one change per signal per falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic v_n;
    logic wen_n;
    v_n   = in_tvalid;
    wen_n = 1'b0;
    if (rst_n && !(in_tvalid && !in_fire)) begin
      // nothing on offer, or the last word was just taken
      v_n = 1'b0;
      if (due_results.size() == 0) quiet++;
      else quiet = 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_q.size() > 0) begin
        case (sample_q[0].op)
          OP_WORD: begin
            v_n      = 1'b1;
            in_tuser <= sample_q[0].kind;
            in_tdata <= {{(DATA_W - TW - 1){1'b0}}, sample_q[0].stamp, sample_q[0].lvl};
            gap_left = sample_q[0].gap;
            void'(sample_q.pop_front());
          end
          OP_CFG: begin
            // only while nothing is in flight
            if (quiet >= SETTLE) begin
              wen_n = 1'b1;
              cfg_addr  <= sample_q[0].addr;
              cfg_wdata <= sample_q[0].data;
              case (sample_q[0].addr)
                REG_ENABLE:        cf_en          = sample_q[0].data[0];
                REG_CONFIRM_DELAY: cf_confirm     = sample_q[0].data[MS_W-1:0];
                REG_WINDOW:        cf_window      = sample_q[0].data[MS_W-1:0];
                REG_HIGH_LIMIT:    cf_hi_limit    = sample_q[0].data[MS_W-1:0];
                REG_EDGE_LIMIT:    cf_rise_limit  = sample_q[0].data[EDGE_LIM_W-1:0];
                REG_CYCLES_LOCK:   cf_lock_streak = sample_q[0].data[STREAK_W-1:0];
                REG_LOCKOUT_LEN:   cf_lock_len    = sample_q[0].data[MS_W-1:0];
                default: ;
              endcase
              cfg_writes++;
              void'(sample_q.pop_front());
            end
          end
          default: begin
            if (quiet >= SETTLE) void'(sample_q.pop_front());
          end
        endcase
      end else begin
        stim_done = 1'b1;
      end
    end
    in_tvalid <= v_n;
    cfg_wen   <= wen_n;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall per result, calm stretches, one long hold
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy_n;
    if (out_fire) begin
      if (results_seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall_left = rx_calm ? 0 : $urandom_range(0, 5);
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy_n = 1'b0;
    end else if (!hold_done && results_seen >= hold_after) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      rdy_n     = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy_n = 1'b0;
    end else begin
      rdy_n = 1'b1;
    end
    out_tready <= rdy_n;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          n;
    int unsigned win;
    logic [MS_W-1:0] c_confirm, c_window, c_hi, c_len;
    logic [EDGE_LIM_W-1:0] c_rise;
    logic [STREAK_W-1:0]   c_streak;

    // directed, reset register values: cancel in idle, confirm and window, a full noisy cycle
    push_word(KIND_LEVEL, 1'b0, '0);
    push_word(KIND_LEVEL, 1'b1, '0);        // opens a cycle
    push_word(KIND_CANCEL, 1'b0, '0);       // cancel while confirming
    push_word(KIND_CANCEL, 1'b1, STAMP_MAX); // cancel in idle, no effect
    push_word(KIND_LEVEL, 1'b1, 48'd100);
    push_word(KIND_LEVEL, 1'b1, 48'd5100);  // confirm delay met
    push_word(KIND_LEVEL, 1'b0, 48'd5200);
    push_word(KIND_CANCEL, 1'b0, 48'd5300); // cancel in the window
    push_word(KIND_LEVEL, 1'b1, 48'd6000);
    push_word(KIND_LEVEL, 1'b1, 48'd26000); // ready
    push_word(KIND_LEVEL, 1'b1, 48'd26000); // window over, noisy, no lock yet

    // directed, zero delays and streak limit: one noisy cycle locks
    load_settings(1'b1, '0, '0, '0, EDGE_LIMIT_RST, '0, MS_MAX);
    push_word(KIND_LEVEL, 1'b1, 48'd30000);
    push_word(KIND_LEVEL, 1'b0, 48'd30000);
    push_word(KIND_LEVEL, 1'b0, 48'd30002); // lockout begins
    push_word(KIND_LEVEL, 1'b1, 48'd40000); // still locked
    push_word(KIND_CANCEL, 1'b1, 48'd40000); // cancel in lockout, no effect
    push_word(KIND_LEVEL, 1'b1, 48'd30002 + MS_MAX); // leaves to idle only
    push_word(KIND_LEVEL, 1'b1, 48'd30002 + MS_MAX); // now a cycle opens
    push_op(OP_CFG, REG_ENABLE, '0);
    push_word(KIND_LEVEL, 1'b1, 48'd16807300); // disabled: cycle cleared
    t_now = 48'd16807400;

    // random phases over a spread of settings
    for (int p = 0; p < 14; p++) begin
      n = 116;
      case (p)
        3: begin
          load_settings(1'b1, '0, '0, '0, '0, '0, '0);
          win = 0;
        end
        7: begin
          load_settings(1'b1, MS_MAX, MS_MAX, MS_MAX, '1, '1, MS_MAX);
          win = MS_MAX;
          n   = 100;
        end
        default: begin
          c_confirm = $urandom_range(0, 20);
          c_window  = $urandom_range(0, 60);
          c_hi      = $urandom_range(0, 40);
          c_rise    = $urandom_range(0, 8);
          c_streak  = $urandom_range(0, 4);
          c_len     = $urandom_range(0, 300);
          // one phase runs with the filter switched off
          load_settings(p != 10, c_confirm, c_window, c_hi, c_rise, c_streak, c_len);
          win = c_window;
          if (p == 10) n = 40;
        end
      endcase
      if (p == 5) begin
        // receiver goes quiet here while the sender keeps offering back to back
        gen_phase(n / 2, win, 1'b0);
        hold_after = words_queued;
        tx_calm    = 1'b1;
        gen_phase(60, win, 1'b1);
        tx_calm    = 1'b0;
        gen_phase(n / 2, win, 1'b0);
      end else if (p == 9) begin
        gen_phase(n / 2, win, 1'b0);
        push_op(OP_DRAIN, REG_ENABLE, '0);
        gen_phase(n / 2, win, 1'b0);
      end else begin
        gen_phase(n, win, 1'b0);
      end
    end

    // directed, top of the time range: lockout end saturates, stamp jumps back
    load_settings(1'b1, '0, '0, '0, '0, '0, MS_MAX);
    push_word(KIND_LEVEL, 1'b1, STAMP_MAX - 10);
    push_word(KIND_LEVEL, 1'b0, STAMP_MAX - 10);
    push_word(KIND_LEVEL, 1'b0, STAMP_MAX - 5);  // lockout to the end of time
    push_word(KIND_LEVEL, 1'b1, STAMP_MAX - 1);
    push_word(KIND_LEVEL, 1'b1, STAMP_MAX);      // out of lockout
    push_word(KIND_LEVEL, 1'b1, STAMP_MAX);      // opens a cycle
    push_word(KIND_LEVEL, 1'b1, 48'd3);          // stamp went back
    push_word(KIND_CANCEL, 1'b0, 48'd3);

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (!timed_out && !(stim_done && due_results.size() == 0)) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (due_results.size() != 0) begin
      errors++;
      $display("%0d result words never arrived", due_results.size());
    end
    $display("%0d words in, %0d results, %0d register writes", words_in, results_seen,
             cfg_writes);
    $display("%0d ready pulses, %0d windows judged, %0d lockouts, %0d cancels, %0d errors",
             readies, windows, lockouts, cancels, errors);
    if (timed_out) begin
      $display("watchdog expired after %0d idle cycles", WD_LIMIT);
      $display("FAILURE");
    end else if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
